@@ hw/rtl/bat_pkg.sv @@
// Shared types and constants for the breakpoint address table.
package bat_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int ADDR_W      = 64;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ENTRY_W     = 5;
  localparam int REQ_W       = 3;
  localparam int IN_DATA_W   = 72;
  localparam int OUT_DATA_W  = 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_TOGGLE = 3'd2,
    REQ_CHECK  = 3'd3,
    REQ_HAS    = 3'd4,
    REQ_CLEAR  = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_PRESENT   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Update command broadcast to every cell; the strobes are already qualified.
  typedef struct packed {
    logic              add;
    logic              remove;
    logic              toggle;
    logic              clear;
    logic [ADDR_W-1:0] address;
  } bat_cmd_t;

  // Contents of one cell, handed to its lower neighbor.
  typedef struct packed {
    logic              valid;
    logic              enabled;
    logic [ADDR_W-1:0] address;
  } bat_link_t;

endpackage

@@ hw/rtl/bat_cell.sv @@
// One table slot: holds an address and its enable bit and shifts down on removal.
module bat_cell import bat_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  bat_cmd_t  cmd,
  input  bat_link_t upper,
  input  logic      lower_valid,
  input  logic      match_below,
  output bat_link_t cur,
  output logic      match,
  output logic      match_thru
);

  logic [ADDR_W-1:0] addr;
  logic              enabled;
  logic              valid;
  logic              append_here;
  logic              shift_in;

  assign match       = valid && (addr == cmd.address);
  assign match_thru  = match_below || match;
  // The first empty slot takes an appended address.
  assign append_here = cmd.add && !valid && lower_valid;
  // Every slot at or above the removed one takes its upper neighbor's contents.
  assign shift_in    = cmd.remove && match_thru;

  assign cur.valid   = valid;
  assign cur.enabled = enabled;
  assign cur.address = addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      enabled <= 1'b0;
    end else if (cmd.clear) begin
      valid   <= 1'b0;
      enabled <= 1'b0;
    end else if (append_here) begin
      valid   <= 1'b1;
      enabled <= 1'b1;
    end else if (shift_in) begin
      valid   <= upper.valid;
      enabled <= upper.enabled;
    end else if (cmd.toggle && match) begin
      enabled <= ~enabled;
    end
  end

  always_ff @(posedge clk) begin
    if (append_here) begin
      addr <= cmd.address;
    end else if (shift_in) begin
      addr <= upper.address;
    end
  end

endmodule

@@ hw/rtl/breakpoint_address_table_core.sv @@
// Breakpoint address table: a row of slot cells and the request decode around it.
// A request transfer's result is registered and presented on the master side in the next cycle.
// Throughput: one request per cycle, set by the single compare pass over the cell row.
// A new request is taken while the output register is empty or being read.
// Reset (rst, synchronous, active high) empties the table and drops the output valid.
module breakpoint_address_table_core import bat_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // req_type[2:0], address[66:3], zero pad
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // status[1:0], hit[2], entry_count[7:3]
);

  // Request fields as they arrive on the slave side.
  req_t              req_type;
  logic [ADDR_W-1:0] req_address;
  logic              accept;

  // Per-cell views of the row.
  bat_link_t             cell_state [MAX_ENTRIES];
  bat_link_t             cell_upper [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] cell_valid;
  logic [MAX_ENTRIES-1:0] cell_enabled;
  logic [MAX_ENTRIES-1:0] cell_match;
  logic [MAX_ENTRIES-1:0] cell_thru;
  logic [MAX_ENTRIES-1:0] cell_lower_valid;
  logic [MAX_ENTRIES-1:0] cell_below;

  logic      any_match;
  logic      enabled_match;
  logic      full;
  bat_cmd_t  cmd;

  // Bookkeeping and the output register.
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  status_t            status_next;
  logic               hit_next;
  status_t            status;
  logic               hit;
  logic [ENTRY_W-1:0] entry_count;

  assign req_type    = req_t'(s_tdata[REQ_W-1:0]);
  assign req_address = s_tdata[REQ_W +: ADDR_W];

  // The output register frees up in the same cycle it is read.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Wiring of the row: cell 0 sits at the bottom, the top cell shifts in an empty slot.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    if (i == MAX_ENTRIES - 1) begin : g_top
      assign cell_upper[i] = '0;
    end else begin : g_mid
      assign cell_upper[i] = cell_state[i+1];
    end
    if (i == 0) begin : g_bottom
      assign cell_lower_valid[i] = 1'b1;
      assign cell_below[i]       = 1'b0;
    end else begin : g_above
      assign cell_lower_valid[i] = cell_valid[i-1];
      assign cell_below[i]       = cell_thru[i-1];
    end

    assign cell_valid[i]   = cell_state[i].valid;
    assign cell_enabled[i] = cell_state[i].enabled;

    bat_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .upper       (cell_upper[i]),
      .lower_valid (cell_lower_valid[i]),
      .match_below (cell_below[i]),
      .cur         (cell_state[i]),
      .match       (cell_match[i]),
      .match_thru  (cell_thru[i])
    );
  end

  // Entries are never duplicated, so at most one cell matches.
  assign any_match     = cell_thru[MAX_ENTRIES-1];
  assign enabled_match = |(cell_match & cell_enabled);
  assign full          = cell_valid[MAX_ENTRIES-1];

  // Decode the request into qualified cell commands and the result fields.
  always_comb begin
    cmd         = '0;
    cmd.address = req_address;
    status_next = ST_OK;
    hit_next    = 1'b0;
    count_next  = count;
    case (req_type)
      REQ_ADD: begin
        if (full) begin
          status_next = ST_FULL;
        end else if (any_match) begin
          status_next = ST_PRESENT;
        end else begin
          cmd.add    = accept;
          count_next = count + 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (any_match) begin
          cmd.remove = accept;
          count_next = count - 1'b1;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      REQ_TOGGLE: begin
        if (any_match) begin
          cmd.toggle = accept;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      REQ_CHECK: begin
        hit_next = enabled_match;
      end
      REQ_HAS: begin
        hit_next = any_match;
      end
      REQ_CLEAR: begin
        cmd.clear  = accept;
        count_next = '0;
      end
      default: begin
        // Unused request codes leave the table alone and report ok.
      end
    endcase
  end

  // Entry count and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      hit         <= hit_next;
      entry_count <= ENTRY_W'(count_next);
    end
  end

  assign m_tdata = {entry_count, hit, status};

  // The count always equals the number of occupied cells.
  assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(count))
    else $error("entry count out of step with the occupied cells");

  // Occupied cells stay packed at the bottom of the row.
  assert property (@(posedge clk) disable iff (rst)
    (cell_valid & (cell_valid + 1'b1)) == '0)
    else $error("table entries are not packed");

  // A successful add grows the table by exactly one entry.
  assert property (@(posedge clk) disable iff (rst)
    accept && req_type == REQ_ADD && status_next == ST_OK
    |=> count == $past(count) + 1'b1)
    else $error("successful add did not grow the table by one");

  // No two occupied cells hold the same address.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_match))
    else $error("duplicate address held in the table");

endmodule

@@ tb/tb_breakpoint_address_table_core.sv @@
// Self-checking testbench for the breakpoint address table core.
module tb_breakpoint_address_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bat_pkg::*;

  // Timing of the run.
  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 9;
  // The longest quiet stretch of a correct run is the forced receiver stall below,
  // so the watchdog limit sits well above it.
  localparam int QUIET_LIMIT  = 2000;
  localparam int STALL_CYCLES = 300;
  // The core answers in the cycle after a request transfer, so the TAIL_CYCLES tail
  // is enough to catch a stray reply after the last expected one.
  localparam int TAIL_CYCLES  = 4;
  localparam int RANDOM_ITEMS = 430;
  localparam int BURST_ITEMS  = 40;
  localparam int POOL_SIZE    = 20;

  // Request types six and seven are not decoded by the core and must be ignored.
  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

  localparam logic [ADDR_W-1:0] ADDR_ZERO = '0;
  localparam logic [ADDR_W-1:0] ADDR_ONES = '1;

  // One reply of the table, as the predictor expects it.
  typedef struct {
    status_t          status;
    logic             hit;
    logic [ENTRY_W-1:0] count;
  } table_reply_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;

  breakpoint_address_table_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Shadow copy of the table that the predictor keeps in step with the core.
  logic [ADDR_W-1:0] shadow_addr [MAX_ENTRIES];
  logic              shadow_on   [MAX_ENTRIES];
  int                shadow_held;

  // Replies still owed by the core, oldest first.
  table_reply_t pending_replies [$];

  // Addresses that the random traffic draws from, so that hits and duplicates are common.
  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

  int send_idle_pct;
  int recv_idle_pct;
  int stall_left;
  int quiet_cycles;
  int mismatch_count;
  int request_count;
  int reply_count;
  int full_rejects;
  int predicted_hits;

  // The clock starts low, so the first rising edge comes half a period in.
  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // Every mismatch goes through here: one line on the log and one more on the count.
  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int find_slot(input logic [ADDR_W-1:0] addr);
    int i;
    for (i = 0; i < shadow_held; i++) begin
      if (shadow_addr[i] == addr) return i;
    end
    return -1;
  endfunction

  // Applies one request to the shadow table and returns the reply the core owes for it.
  function automatic table_reply_t table_response(input logic [REQ_W-1:0] kind,
                                                  input logic [ADDR_W-1:0] addr);
    table_reply_t reply;
    int slot;
    int i;
    reply.status = ST_OK;
    reply.hit    = 1'b0;
    slot         = find_slot(addr);
    case (kind)
      REQ_ADD: begin
        // A full table is rejected before the duplicate test is made.
        if (shadow_held >= MAX_ENTRIES) begin
          reply.status = ST_FULL;
          full_rejects++;
        end else if (slot >= 0) begin
          reply.status = ST_PRESENT;
        end else begin
          shadow_addr[shadow_held] = addr;
          shadow_on[shadow_held]   = 1'b1;
          shadow_held++;
        end
      end
      REQ_REMOVE: begin
        if (slot < 0) begin
          reply.status = ST_NOT_FOUND;
        end else begin
          // Later entries move down one slot so the table stays packed.
          for (i = slot; i < shadow_held - 1; i++) begin
            shadow_addr[i] = shadow_addr[i + 1];
            shadow_on[i]   = shadow_on[i + 1];
          end
          shadow_held--;
        end
      end
      REQ_TOGGLE: begin
        if (slot < 0) reply.status = ST_NOT_FOUND;
        else shadow_on[slot] = ~shadow_on[slot];
      end
      REQ_CHECK: begin
        for (i = 0; i < shadow_held; i++) begin
          if (shadow_on[i] && shadow_addr[i] == addr) reply.hit = 1'b1;
        end
      end
      REQ_HAS: begin
        reply.hit = (slot >= 0);
      end
      REQ_CLEAR: begin
        shadow_held = 0;
        for (i = 0; i < MAX_ENTRIES; i++) shadow_on[i] = 1'b0;
      end
      default: begin
        // Spare request types leave the table alone and answer with the plain count.
      end
    endcase
    if (reply.hit) predicted_hits++;
    reply.count = ENTRY_W'(shadow_held);
    return reply;
  endfunction

  // Offers one request and returns at the rising edge where it is transferred. The
  // expected reply is queued at that same edge, so it is in place before the reply
  // can come out in the following cycle.
  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [ADDR_W-1:0] addr);
    @(negedge clk);
    // Each cycle the sender sits idle with the chance given by send_idle_pct.
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - ADDR_W - REQ_W){1'b0}}, addr, kind};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    request_count++;
    pending_replies.push_back(table_response(kind, addr));
  endtask

  // The receiver drives tready at each falling edge. A forced stall, when one is
  // pending, overrides the random idling and is counted down here cycle by cycle.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every reply transfer is compared field by field with the oldest expectation.
  always @(posedge clk) begin
    table_reply_t want;
    logic [1:0]         got_status;
    logic               got_hit;
    logic [ENTRY_W-1:0] got_count;
    got_status = m_tdata[1:0];
    got_hit    = m_tdata[2];
    got_count  = m_tdata[7:3];
    if (!rst && m_tvalid && m_tready) begin
      reply_count++;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("reply %0d (data %h) came with no request pending",
                                  reply_count, m_tdata));
      end else begin
        want = pending_replies.pop_front();
        if (got_status != want.status)
          report_mismatch($sformatf("reply %0d: status %0d, expected %0d", reply_count,
                                    got_status, want.status));
        if (got_hit != want.hit)
          report_mismatch($sformatf("reply %0d: hit %0d, expected %0d", reply_count,
                                    got_hit, want.hit));
        if (got_count != want.count)
          report_mismatch($sformatf("reply %0d: entry count %0d, expected %0d",
                                    reply_count, got_count, want.count));
      end
    end
  end

  // The watchdog ends a run in which neither side has moved a transfer for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles, %0d replies still owed",
                 QUIET_LIMIT, pending_replies.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic logic [ADDR_W-1:0] random_address();
    return {$urandom(), $urandom()};
  endfunction

  // The pool holds both extremes, random addresses, and near neighbors that differ
  // from another pool entry in a single bit, which stresses the address compare.
  task automatic fill_pool();
    int k;
    addr_pool[0] = ADDR_ZERO;
    addr_pool[1] = ADDR_ONES;
    for (k = 2; k < POOL_SIZE / 2; k++) addr_pool[k] = random_address();
    for (k = POOL_SIZE / 2; k < POOL_SIZE; k++)
      addr_pool[k] = addr_pool[$urandom_range(POOL_SIZE / 2 - 1)]
                     ^ (64'd1 << $urandom_range(ADDR_W - 1));
  endtask

  // Mostly table maintenance and lookups; clears are rare so the table gets to fill up.
  function automatic logic [REQ_W-1:0] pick_kind();
    int roll;
    roll = $urandom_range(999);
    if (roll < 330) return REQ_ADD;
    if (roll < 450) return REQ_REMOVE;
    if (roll < 580) return REQ_TOGGLE;
    if (roll < 800) return REQ_CHECK;
    if (roll < 940) return REQ_HAS;
    if (roll < 970) return REQ_CLEAR;
    if (roll < 985) return REQ_SPARE_6;
    return REQ_SPARE_7;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    if ($urandom_range(99) < 85) return addr_pool[$urandom_range(POOL_SIZE - 1)];
    return random_address();
  endfunction

  task automatic send_random_items(input int n);
    logic [REQ_W-1:0] kind;
    int k;
    for (k = 0; k < n; k++) begin
      kind = pick_kind();
      send_request(kind, pick_address());
      // A clear starts a new session, so part of the pool is renewed with it.
      if (kind == REQ_CLEAR) addr_pool[$urandom_range(POOL_SIZE - 1, 2)] = random_address();
    end
  endtask

  // Fills the table to its limit, then offers a duplicate of a held address while
  // full: the full status must win over the already-present status.
  task automatic test_table_fill();
    int k;
    send_request(REQ_ADD, ADDR_ZERO);
    send_request(REQ_ADD, ADDR_ONES);
    for (k = 0; k < MAX_ENTRIES - 2; k++)
      send_request(REQ_ADD, (64'd1 << (4 * k + 3)) | 64'h5);
    send_request(REQ_ADD, ADDR_ONES);
  endtask

  // Lookups of enabled and disabled entries, removal at the head of the table,
  // misses on remove and toggle, and a duplicate add once there is room again.
  task automatic test_lookup_and_edit();
    send_request(REQ_TOGGLE, ADDR_ONES);
    send_request(REQ_CHECK, ADDR_ONES);
    send_request(REQ_HAS, ADDR_ONES);
    send_request(REQ_CHECK, ADDR_ZERO);
    send_request(REQ_REMOVE, ADDR_ZERO);
    send_request(REQ_TOGGLE, ADDR_ZERO);
    send_request(REQ_REMOVE, 64'h0123_4567_89AB_CDEF);
    send_request(REQ_ADD, ADDR_ONES);
  endtask

  // Spare request types must leave the table as it is; clear then empties it.
  task automatic test_spare_and_clear();
    send_request(REQ_SPARE_6, ADDR_ONES);
    send_request(REQ_SPARE_7, ADDR_ZERO);
    send_request(REQ_CLEAR, ADDR_ONES);
    send_request(REQ_HAS, ADDR_ONES);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering, so
  // the output register fills and the core has to stall its request side.
  task automatic test_output_backpressure();
    stall_left = STALL_CYCLES;
    send_random_items(BURST_ITEMS);
  endtask

  task automatic test_random_traffic(input int n);
    fill_pool();
    send_random_items(n);
  endtask

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    m_tready       = 1'b0;
    send_idle_pct  = 17;
    recv_idle_pct  = 76;
    stall_left     = 0;
    quiet_cycles   = 0;
    mismatch_count = 0;
    request_count  = 0;
    reply_count    = 0;
    full_rejects   = 0;
    predicted_hits = 0;
    shadow_held    = 0;
    for (int i = 0; i < MAX_ENTRIES; i++) shadow_on[i] = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // First phase: a busy sender and a receiver that is mostly stalled.
    test_table_fill();
    test_lookup_and_edit();
    test_spare_and_clear();
    test_random_traffic(RANDOM_ITEMS);

    // Second phase: the idling is swapped between the two sides.
    send_idle_pct = 76;
    recv_idle_pct = 17;
    test_random_traffic(RANDOM_ITEMS);

    // Last phase: no idling at all, plus one long forced stall on the reply side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    test_random_traffic(RANDOM_ITEMS);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests and checked %0d replies; %0d mismatches.",
             request_count, reply_count, mismatch_count);
    $display("The table refused %0d adds as full and reported %0d hits.",
             full_rejects, predicted_hits);
    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
